[hdl/fvdt_pkg.sv]
// ----------------------------------------------------------------------------
// fvdt_pkg
// Shared types, constants and rounding helpers for the single-precision
// vector dot / transform core.
// ----------------------------------------------------------------------------
package fvdt_pkg;

	localparam int          NUM_PAIRS  = 8;
	localparam int          LANE_LAT   = 15;
	localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
	localparam logic        ACT_DOT    = 1'b0;
	localparam logic        ACT_XFORM  = 1'b1;

	// normalised intermediate: leading one at man[49], biased exponent of that bit
	typedef struct packed {
		logic               sign;
		logic signed [10:0] exp;
		logic [49:0]        man;
		logic               zero;
		logic               inf;
		logic               nan;
	} fvdt_norm_t;

	// leading zero count of a 50-bit word
	function automatic logic [5:0] fvdt_lzc50(input logic [49:0] v);
		logic [5:0] n;
		n = 6'd50;
		for (int i = 0; i < 50; i++) begin
			if (v[i]) n = 6'(49 - i);
		end
		return n;
	endfunction

	// round to nearest even and pack, with gradual underflow
	function automatic logic [31:0] fvdt_round(input fvdt_norm_t n);
		logic [99:0]        wide;
		logic [49:0]        t;
		logic               st;
		logic signed [10:0] shv;
		logic [6:0]         sh;
		logic [7:0]         ef;
		logic               inc;
		logic [31:0]        sum;
		wide = '0;
		t    = n.man;
		st   = 1'b0;
		ef   = 8'd0;
		if (n.exp >= 11'sd1) begin
			ef = n.exp[7:0];
		end else begin
			shv  = 11'sd1 - n.exp;
			sh   = (shv > 11'sd51) ? 7'd51 : shv[6:0];
			wide = {n.man, 50'b0} >> sh;
			t    = wide[99:50];
			st   = |wide[49:0];
		end
		st  = st | (|t[24:0]);
		inc = t[25] & (st | t[26]);
		sum = {1'b0, ef, t[48:26]} + {31'b0, inc};
		if (n.nan)                       return CANON_NAN;
		else if (n.inf)                  return {n.sign, 8'hFF, 23'b0};
		else if (n.zero)                 return {n.sign, 31'b0};
		else if (n.exp >= 11'sd255)      return {n.sign, 8'hFF, 23'b0};
		else                             return {n.sign, sum[30:0]};
	endfunction

endpackage

[hdl/fvdt_fmul.sv]
// ----------------------------------------------------------------------------
// fvdt_fmul
// Three-stage single-precision multiplier: significand product, normalise,
// round.
// ----------------------------------------------------------------------------
module fvdt_fmul import fvdt_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] z
);

	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [7:0]  ea, eb;
	logic [23:0] ma, mb;

	logic        sign_s1, nan_s1, inf_s1;
	logic [9:0]  esum_s1;
	logic [47:0] prod_s1;
	fvdt_norm_t  nrm, nrm_s2;
	logic [5:0]  lz;

	// operand decode
	always_comb begin
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
		a_zero = (a[30:0] == '0);
		b_zero = (b[30:0] == '0);
		ea     = (a[30:23] == 8'h00) ? 8'd1 : a[30:23];
		eb     = (b[30:23] == 8'h00) ? 8'd1 : b[30:23];
		ma     = {(a[30:23] != 8'h00), a[22:0]};
		mb     = {(b[30:23] != 8'h00), b[22:0]};
	end

	// stage 1: significand product
	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1 <= a[31] ^ b[31];
			nan_s1  <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
			inf_s1  <= a_inf | b_inf;
			esum_s1 <= {2'b0, ea} + {2'b0, eb};
			prod_s1 <= ma * mb;
		end
	end

	// normalise the product
	always_comb begin
		lz       = fvdt_lzc50({prod_s1, 2'b0});
		nrm.sign = sign_s1;
		nrm.nan  = nan_s1;
		nrm.inf  = inf_s1 & ~nan_s1;
		nrm.zero = (prod_s1 == '0);
		nrm.man  = {prod_s1, 2'b0} << lz;
		nrm.exp  = $signed({1'b0, esum_s1}) - 11'sd126 - $signed({5'b0, lz});
	end

	// stage 2: normalised, stage 3: rounded
	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s2 <= nrm;
			z      <= fvdt_round(nrm_s2);
		end
	end

endmodule

[hdl/fvdt_fadd.sv]
// ----------------------------------------------------------------------------
// fvdt_fadd
// Four-stage single-precision adder: align, add, normalise, round.
// ----------------------------------------------------------------------------
module fvdt_fadd import fvdt_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] z
);

	logic        a_nan, b_nan, a_inf, b_inf, swap, nan_c, inf_c;
	logic [31:0] big, sml;
	logic [7:0]  eb_big, eb_sml, d;
	logic [101:0] shw;
	logic [50:0] bal;

	logic        sign_s1, zsign_s1, sub_s1, nan_s1, inf_s1, isign_s1;
	logic [7:0]  exp_s1;
	logic [50:0] opa_s1, opb_s1;

	logic        sign_s2, zsign_s2, nan_s2, inf_s2, isign_s2;
	logic [7:0]  exp_s2;
	logic [50:0] sum_s2;

	fvdt_norm_t  nrm, nrm_s3;
	logic [5:0]  lz;

	// specials, magnitude order and alignment
	always_comb begin
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
		nan_c  = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
		inf_c  = a_inf | b_inf;
		swap   = (b[30:0] > a[30:0]);
		big    = swap ? b : a;
		sml    = swap ? a : b;
		eb_big = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
		eb_sml = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
		d      = eb_big - eb_sml;
		shw    = {1'b0, (sml[30:23] != 8'h00), sml[22:0], 26'b0, 51'b0} >> d;
		bal    = shw[101:51];
		bal[0] = bal[0] | (|shw[50:0]);
	end

	// stage 1: aligned operands
	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1  <= big[31];
			zsign_s1 <= a[31] & b[31];
			sub_s1   <= a[31] ^ b[31];
			nan_s1   <= nan_c;
			inf_s1   <= inf_c;
			isign_s1 <= a_inf ? a[31] : b[31];
			exp_s1   <= eb_big;
			opa_s1   <= {1'b0, (big[30:23] != 8'h00), big[22:0], 26'b0};
			opb_s1   <= bal;
		end
	end

	// stage 2: sum
	always_ff @(posedge clk) begin
		if (en) begin
			sign_s2  <= sign_s1;
			zsign_s2 <= zsign_s1;
			nan_s2   <= nan_s1;
			inf_s2   <= inf_s1;
			isign_s2 <= isign_s1;
			exp_s2   <= exp_s1;
			sum_s2   <= sub_s1 ? (opa_s1 - opb_s1) : (opa_s1 + opb_s1);
		end
	end

	// normalise the sum
	always_comb begin
		lz       = fvdt_lzc50(sum_s2[49:0]);
		nrm.nan  = nan_s2;
		nrm.inf  = inf_s2 & ~nan_s2;
		nrm.zero = (sum_s2 == '0);
		nrm.sign = nrm.inf ? isign_s2 : (nrm.zero ? zsign_s2 : sign_s2);
		if (sum_s2[50]) begin
			nrm.man = {sum_s2[50:2], sum_s2[1] | sum_s2[0]};
			nrm.exp = $signed({3'b0, exp_s2}) + 11'sd1;
		end else begin
			nrm.man = sum_s2[49:0] << lz;
			nrm.exp = $signed({3'b0, exp_s2}) - $signed({5'b0, lz});
		end
	end

	// stage 3: normalised, stage 4: rounded
	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s3 <= nrm;
			z      <= fvdt_round(nrm_s3);
		end
	end

endmodule

[hdl/fvdt_lane.sv]
// ----------------------------------------------------------------------------
// fvdt_lane
// One output element: four products, then an ordered chain of three adds
// with the later products delayed to meet the running sum.
// ----------------------------------------------------------------------------
module fvdt_lane import fvdt_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [3:0][31:0] a,
	input  logic [3:0][31:0] b,
	output logic [31:0]      z
);

	logic [3:0][31:0] prod;
	logic [31:0]      acc0, acc1;
	logic [3:0][31:0] p2_dly_q;
	logic [7:0][31:0] p3_dly_q;

	// products
	for (genvar j = 0; j < 4; j++) begin : g_mul
		fvdt_fmul u_mul (.clk(clk), .en(en), .a(a[j]), .b(b[j]), .z(prod[j]));
	end

	// delay later products to meet the running sum
	always_ff @(posedge clk) begin
		if (en) begin
			p2_dly_q <= {p2_dly_q[2:0], prod[2]};
			p3_dly_q <= {p3_dly_q[6:0], prod[3]};
		end
	end

	// ordered sum chain
	fvdt_fadd u_add0 (.clk(clk), .en(en), .a(prod[0]), .b(prod[1]),     .z(acc0));
	fvdt_fadd u_add1 (.clk(clk), .en(en), .a(acc0),    .b(p2_dly_q[3]), .z(acc1));
	fvdt_fadd u_add2 (.clk(clk), .en(en), .a(acc1),    .b(p3_dly_q[7]), .z(z));

endmodule

[hdl/float_vector_dot_and_transform_core.sv]
// ----------------------------------------------------------------------------
// float_vector_dot_and_transform_core
// Four-element single-precision inner product and 4x4 matrix transform.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word per cycle: action, x and
// y vectors. Action 0 returns y with element 3 replaced by the ordered inner
// product of x and y; action 1 returns the column-major matrix times y.
// Output channel (out_valid/out_ready) gives one word per input word, in order.
// Configuration channel (cfg_valid/cfg_ready) writes a 64-bit matrix pair
// register selected by cfg_index; indexes of 8 and above are dropped. Write
// only while no word is in flight.
// Each word passes through the multipliers, the three chained adders and the
// output register. Throughput is one word per cycle while the output is not stalled.
// When the receiver stalls with a word waiting at the output, the whole
// pipeline holds and in_ready falls; nothing is lost or repeated.
// Reset clears the matrix registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module float_vector_dot_and_transform_core import fvdt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] x_elem0,
	input  logic [31:0] x_elem1,
	input  logic [31:0] x_elem2,
	input  logic [31:0] x_elem3,
	input  logic [31:0] y_elem0,
	input  logic [31:0] y_elem1,
	input  logic [31:0] y_elem2,
	input  logic [31:0] y_elem3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] r_elem0,
	output logic [31:0] r_elem1,
	output logic [31:0] r_elem2,
	output logic [31:0] r_elem3,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [NUM_PAIRS-1:0][63:0]  mat_q;
	logic [15:0][31:0]           melem;
	logic [LANE_LAT:0]           vld_q;
	logic                        en;
	logic [3:0][31:0]            yv, xv;
	logic [3:0][3:0][31:0]       opa;
	logic [3:0][31:0]            lane_z;
	logic [LANE_LAT-1:0][127:0]  y_dly_q;
	logic [LANE_LAT-1:0]         act_dly_q;
	logic [127:0]                y_end;

	assign en        = ~vld_q[LANE_LAT] | out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[LANE_LAT];
	assign yv        = {y_elem3, y_elem2, y_elem1, y_elem0};
	assign xv        = {x_elem3, x_elem2, x_elem1, x_elem0};

	// matrix pair registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (cfg_valid && (cfg_index < 8'(NUM_PAIRS))) begin
			mat_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// matrix elements: even index in the high half of a pair
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			melem[k] = (k % 2 == 1) ? mat_q[k/2][31:0] : mat_q[k/2][63:32];
		end
	end

	// lane operands: lane 3 takes x for the inner product
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				opa[i][j] = melem[i + 4*j];
			end
		end
		if (action == ACT_DOT) opa[3] = xv;
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		fvdt_lane u_lane (.clk(clk), .en(en), .a(opa[i]), .b(yv), .z(lane_z[i]));
	end

	// word valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LANE_LAT-1:0], in_valid};
		end
	end

	// pass-through y and action alongside the lanes
	always_ff @(posedge clk) begin
		if (en) begin
			y_dly_q   <= {y_dly_q[LANE_LAT-2:0], yv};
			act_dly_q <= {act_dly_q[LANE_LAT-2:0], action};
		end
	end

	assign y_end = y_dly_q[LANE_LAT-1];

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			r_elem3 <= lane_z[3];
			if (act_dly_q[LANE_LAT-1] == ACT_XFORM) begin
				r_elem0 <= lane_z[0];
				r_elem1 <= lane_z[1];
				r_elem2 <= lane_z[2];
			end else begin
				r_elem0 <= y_end[31:0];
				r_elem1 <= y_end[63:32];
				r_elem2 <= y_end[95:64];
			end
		end
	end

endmodule
